// ===== rtl/isbm_pkg.sv =====
`timescale 1ns / 1ps
package isbm_pkg;

    localparam int MAX_DEVICES     = 8;
    localparam int BLOCK_BYTES     = 512;
    localparam int MINIROOT_BLOCKS = 4096;
    localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);

    localparam int BLK_W   = 31;
    localparam int BYTES_W = 24;
    localparam int ILV_W   = 21;
    localparam int NDEV_W  = 4;
    localparam int TOT_W   = 31;
    localparam int PRES_W  = 8;
    localparam int IDX_W   = 3;
    localparam int ST_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // start block after the miniroot offset
    localparam int VBLK_W = BLK_W + 1;
    // request length in blocks
    localparam int SZ_W   = BYTES_W + 1 - BLOCK_SHIFT;

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_NODEV   = 2'd2;
    localparam logic [ST_W-1:0] ST_UNUSED  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERLEAVE = 3'd0,
        CFG_NDEV       = 3'd1,
        CFG_TOTAL      = 3'd2,
        CFG_PRESENT    = 3'd3,
        CFG_MINIROOT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              bad_range;
        logic [SZ_W-1:0]   sz;
        logic [VBLK_W-1:0] blk;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] device_index;
        logic [BLK_W-1:0] device_block;
        logic [ST_W-1:0]  status;
    } t_res;

    typedef struct packed {
        logic [ILV_W-1:0]  chunk;
        logic [NDEV_W-1:0] ndev;
        logic [PRES_W-1:0] present;
    } t_map_cfg;

endpackage

// ===== rtl/isbm_fifo.sv =====
`timescale 1ns / 1ps
module isbm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= f_inc(r_wp);
            if (w_rd) r_rp <= f_inc(r_rp);
            if (w_wr && !w_rd) r_cnt <= r_cnt + CW'(1);
            else if (w_rd && !w_wr) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== rtl/isbm_div.sv =====
`timescale 1ns / 1ps
module isbm_div #(
    parameter int N  = 32,
    parameter int M  = 21,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [N-1:0]  i_num,
    input  logic [M-1:0]  i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [N-1:0]  o_quo,
    output logic [M-1:0]  o_rem,
    output logic [TW-1:0] o_tag
);
    // restoring divider, one quotient bit per stage
    logic          r_v   [1:N];
    logic [M-1:0]  r_rem [1:N];
    logic [N-1:0]  r_num [1:N];
    logic [N-1:0]  r_quo [1:N];
    logic [TW-1:0] r_tag [1:N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic          p_v;
        logic [M-1:0]  p_rem;
        logic [N-1:0]  p_num, p_quo;
        logic [TW-1:0] p_tag;
        logic [M:0]    t;
        logic          ge;

        if (i == 0) begin : g_first
            assign p_v   = i_valid;
            assign p_rem = '0;
            assign p_num = i_num;
            assign p_quo = '0;
            assign p_tag = i_tag;
        end else begin : g_next
            assign p_v   = r_v[i];
            assign p_rem = r_rem[i];
            assign p_num = r_num[i];
            assign p_quo = r_quo[i];
            assign p_tag = r_tag[i];
        end

        assign t  = {p_rem, p_num[N-1]};
        assign ge = (t >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i+1] <= 1'b0;
            else if (i_en) r_v[i+1] <= p_v;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= ge ? M'(t - {1'b0, i_den}) : t[M-1:0];
                r_num[i+1] <= p_num << 1;
                r_quo[i+1] <= {p_quo[N-2:0], ge};
                r_tag[i+1] <= p_tag;
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_quo   = r_quo[N];
    assign o_rem   = r_rem[N];
    assign o_tag   = r_tag[N];
endmodule

// ===== rtl/isbm_front.sv =====
`timescale 1ns / 1ps
module isbm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [isbm_pkg::BLK_W-1:0] i_block_number,
    input  logic [isbm_pkg::BYTES_W-1:0] i_byte_count,
    input  logic                       i_miniroot,
    input  logic [isbm_pkg::TOT_W-1:0] i_total,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output isbm_pkg::t_req             o_q_data
);
    import isbm_pkg::*;

    logic  r_valid;
    t_req  r_req;
    t_req  n_req;
    logic  w_adv;
    logic  [VBLK_W:0] w_end;

    assign w_adv    = !r_valid || !i_q_full;
    assign o_full   = !w_adv;
    assign o_q_push = r_valid;
    assign o_q_data = r_req;

    always_comb begin
        n_req.blk = {1'b0, i_block_number}
                  + (i_miniroot ? VBLK_W'(MINIROOT_BLOCKS) : '0);
        n_req.sz  = SZ_W'(({1'b0, i_byte_count} + (BYTES_W + 1)'(BLOCK_BYTES - 1))
                          >> BLOCK_SHIFT);
        w_end     = {1'b0, n_req.blk} + (VBLK_W + 1)'(n_req.sz);
        n_req.bad_range = (w_end > (VBLK_W + 1)'(i_total));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (w_adv) r_valid <= i_push;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_push) r_req <= n_req;
    end
endmodule

// ===== rtl/isbm_back.sv =====
`timescale 1ns / 1ps
module isbm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  isbm_pkg::t_map_cfg i_cfg,
    input  logic               i_q_empty,
    input  isbm_pkg::t_req     i_q_data,
    output logic               o_q_pop,
    input  logic               i_out_full,
    output logic               o_res_valid,
    output isbm_pkg::t_res     o_res
);
    import isbm_pkg::*;

    localparam int T1_W = 1 + SZ_W + VBLK_W;
    localparam int T2_W = 2 + ILV_W + VBLK_W;
    localparam int P_W  = VBLK_W + ILV_W;

    logic w_en;

    // divider one: start / chunk
    logic              d1_v;
    logic [VBLK_W-1:0] d1_q;
    logic [ILV_W-1:0]  d1_r;
    logic [T1_W-1:0]   d1_t;
    logic              d1_bad;
    logic [SZ_W-1:0]   d1_sz;
    logic [VBLK_W-1:0] d1_blk;
    logic              w_cross;

    // divider two: chunk number / device count
    logic              d2_v;
    logic [VBLK_W-1:0] d2_q;
    logic [NDEV_W-1:0] d2_r;
    logic [T2_W-1:0]   d2_t;

    logic              r_p_valid;
    logic [P_W-1:0]    r_p_prod;
    logic [IDX_W-1:0]  r_p_idx;
    logic              r_p_bad, r_p_cross;
    logic [ILV_W-1:0]  r_p_off;
    logic [VBLK_W-1:0] r_p_blk;
    logic              w_multi;
    logic [IDX_W-1:0]  w_idx;

    // whole pipeline holds when its last item cannot leave
    assign w_en    = !(r_p_valid && i_out_full);
    assign o_q_pop = w_en && !i_q_empty;

    isbm_div #(.N(VBLK_W), .M(ILV_W), .TW(T1_W)) u_div_chunk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (!i_q_empty),
        .i_num   (i_q_data.blk),
        .i_den   (i_cfg.chunk),
        .i_tag   ({i_q_data.bad_range, i_q_data.sz, i_q_data.blk}),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_rem   (d1_r),
        .o_tag   (d1_t)
    );

    assign {d1_bad, d1_sz, d1_blk} = d1_t;
    assign w_cross = ((ILV_W + 1)'(d1_r) + (ILV_W + 1)'(d1_sz)) > (ILV_W + 1)'(i_cfg.chunk);

    isbm_div #(.N(VBLK_W), .M(NDEV_W), .TW(T2_W)) u_div_ndev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (d1_v),
        .i_num   (d1_q),
        .i_den   (i_cfg.ndev),
        .i_tag   ({d1_bad, w_cross, d1_r, d1_blk}),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_rem   (d2_r),
        .o_tag   (d2_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_p_valid <= 1'b0;
        else if (w_en) r_p_valid <= d2_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_prod <= P_W'(d2_q) * P_W'(i_cfg.chunk);
            r_p_idx  <= d2_r[IDX_W-1:0];
            {r_p_bad, r_p_cross, r_p_off, r_p_blk} <= d2_t;
        end
    end

    assign w_multi     = (i_cfg.ndev > NDEV_W'(1));
    assign w_idx       = w_multi ? r_p_idx : '0;
    assign o_res_valid = r_p_valid;

    always_comb begin
        o_res.device_index = w_idx;
        o_res.device_block = w_multi ? BLK_W'(r_p_prod + P_W'(r_p_off)) : r_p_blk[BLK_W-1:0];
        o_res.status       = ST_OK;
        if (r_p_bad || (w_multi && r_p_cross)) begin
            o_res.status       = ST_INVALID;
            o_res.device_index = '0;
            o_res.device_block = '0;
        end else if (!i_cfg.present[w_idx]) begin
            o_res.status       = ST_NODEV;
            o_res.device_index = '0;
            o_res.device_block = '0;
        end
    end
endmodule

// ===== rtl/interleaved_swap_block_map.sv =====
`timescale 1ns / 1ps
// Interleaved swap block mapper. Takes one request (start block, byte count) per
// cycle while o_full is low and returns, in order, the device, the block on that
// device and a status (ok, invalid range or chunk crossing, no device). Throughput
// is one item per cycle unless the result queue stalls. Items pass the front
// classify register, the two bit-serial pipelined dividers (start / chunk, then
// chunk number / device count) and the multiply stage. A front register checks
// the range, a short queue decouples it from the back pipeline, and a small
// result queue holds finished items while pop is low. The user must write
// configuration through the cfg channel only while the block is idle (unchecked).
module interleaved_swap_block_map #(
    parameter int MID_DEPTH = isbm_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = isbm_pkg::OUT_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic [isbm_pkg::BLK_W-1:0]      i_block_number,
    input  logic [isbm_pkg::BYTES_W-1:0]    i_byte_count,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic [isbm_pkg::IDX_W-1:0]      o_device_index,
    output logic [isbm_pkg::BLK_W-1:0]      o_device_block,
    output logic [isbm_pkg::ST_W-1:0]       o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [isbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [isbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import isbm_pkg::*;

    logic [ILV_W-1:0]  r_interleave;
    logic [NDEV_W-1:0] r_ndev;
    logic [TOT_W-1:0]  r_total;
    logic [PRES_W-1:0] r_present;
    logic              r_miniroot;
    t_map_cfg          w_cfg;

    logic w_mid_push, w_mid_full, w_mid_empty, w_mid_pop;
    t_req w_mid_in, w_mid_out;
    logic w_res_valid, w_out_full;
    t_res w_res, w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interleave <= ILV_W'(2048);
            r_ndev       <= NDEV_W'(1);
            r_total      <= '0;
            r_present    <= PRES_W'(1);
            r_miniroot   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INTERLEAVE: r_interleave <= i_cfg_data[ILV_W-1:0];
                CFG_NDEV:       r_ndev       <= i_cfg_data[NDEV_W-1:0];
                CFG_TOTAL:      r_total      <= i_cfg_data[TOT_W-1:0];
                CFG_PRESENT:    r_present    <= i_cfg_data[PRES_W-1:0];
                CFG_MINIROOT:   r_miniroot   <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    // zero chunk means one block; device count clamped to 1..MAX_DEVICES
    always_comb begin
        w_cfg.chunk   = (r_interleave == '0) ? ILV_W'(1) : r_interleave;
        w_cfg.ndev    = (r_ndev == '0) ? NDEV_W'(1)
                      : (r_ndev > NDEV_W'(MAX_DEVICES)) ? NDEV_W'(MAX_DEVICES) : r_ndev;
        w_cfg.present = r_present;
    end

    isbm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_block_number (i_block_number),
        .i_byte_count   (i_byte_count),
        .i_miniroot     (r_miniroot),
        .i_total        (r_total),
        .i_q_full       (w_mid_full),
        .o_q_push       (w_mid_push),
        .o_q_data       (w_mid_in)
    );

    isbm_fifo #(.W($bits(t_req)), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_full  (w_mid_full),
        .o_empty (w_mid_empty)
    );

    isbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_empty   (w_mid_empty),
        .i_q_data    (w_mid_out),
        .o_q_pop     (w_mid_pop),
        .i_out_full  (w_out_full),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    isbm_fifo #(.W($bits(t_res)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .i_pop   (i_pop),
        .o_data  (w_out),
        .o_full  (w_out_full),
        .o_empty (o_empty)
    );

    assign o_device_index = w_out.device_index;
    assign o_device_block = w_out.device_block;
    assign o_status       = w_out.status;

    // a finished item that meets a full result queue must wait unchanged
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_out_full) |=> (w_res_valid && $stable(w_res)))
        else $error("result changed while stalled");

    // status code three is never produced
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_status != ST_UNUSED))
        else $error("undefined status");

    // the front never moves an item on while the queue is full and not draining
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mid_push && w_mid_full && !w_mid_pop) |=> (w_mid_push && $stable(w_mid_in)))
        else $error("front item lost");
endmodule
